@@ sv/sat_pkg.sv @@
// shared types and codes of the sorted address table
package sat_pkg;

  localparam int unsigned KEY_W  = 48;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned OUT_CNT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_TOP,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [KEY_W-1:0]  address;
    logic [SIZE_W-1:0] alloc_size;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 hit;
    logic [KEY_W-1:0]     hit_address;
    logic [SIZE_W-1:0]    hit_size;
    logic [OUT_CNT_W-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } rec_t;

  typedef struct packed {
    logic    load;
    idx_op_e idx_op;
    logic    rd_en;
    logic    rd_next;
    logic    wr_en;
    logic    wr_new;
    logic    wr_up;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    save_hit;
    logic    res_valid;
    status_e res_status;
    logic    res_hit;
    logic    res_addr;
    logic    res_size_ram;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic key_ge;
    logic key_eq;
    logic idx_zero;
    logic idx_last;
    logic shf_last;
    logic is_find;
  } sts_t;

endpackage

@@ sv/sorted_address_table_top.sv @@
// Sorted address table: keeps up to TABLE_DEPTH (address, size) records in ascending
// address order in one single-port-read memory with registered read. A request is
// taken when start_i is high and busy_o is low; its one result word shows on res_o
// for a single cycle with res_valid_o, and cannot be held off. Timing is set by the
// memory, a read and then a compare or write per record: an insert walks down from
// the top, moving each record at or above its address one slot up, then writes the
// new one; a find scans up from slot zero to the match; a remove scans, then shifts down.
// Full table, empty table and unused opcodes answer straight from idle. No clearing pass
// after reset.
module sorted_address_table_top
  import sat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  cmd_t cmd;
  sts_t sts;

  sat_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .opcode_i(req_i.opcode),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  sat_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

@@ sv/sat_ram.sv @@
// generic single write, single read ram with registered read data
module sat_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ sv/sat_ctrl.sv @@
// sequencer for search, shift and result of each request
module sat_ctrl
  import sat_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] opcode_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_INS_HEAD = 3'd3;
  localparam logic [2:0] S_SRCH_RD  = 3'd4;
  localparam logic [2:0] S_SRCH_CMP = 3'd5;
  localparam logic [2:0] S_SHF_RD   = 3'd6;
  localparam logic [2:0] S_SHF_WR   = 3'd7;

  logic [2:0] state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.idx_op = IDX_HOLD;
    cmd_o.res_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (opcode_i)
            OP_INSERT: begin
              if (sts_i.cnt_full) begin
                cmd_o.res_valid = 1'b1;
                cmd_o.res_status = ST_FULL;
              end else if (sts_i.cnt_zero) begin
                cmd_o.idx_op = IDX_ZERO;
                state_d = S_INS_HEAD;
              end else begin
                cmd_o.idx_op = IDX_TOP;
                state_d = S_INS_RD;
              end
            end
            OP_REMOVE, OP_FIND: begin
              if (sts_i.cnt_zero) begin
                cmd_o.res_valid = 1'b1;
                cmd_o.res_status = ST_EMPTY;
              end else begin
                cmd_o.idx_op = IDX_ZERO;
                state_d = S_SRCH_RD;
              end
            end
            default: begin
              cmd_o.res_valid = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wr_up = 1'b1;
        if (sts_i.key_ge) begin
          // move this record one slot up and keep looking below
          if (sts_i.idx_zero) begin
            state_d = S_INS_HEAD;
          end else begin
            cmd_o.idx_op = IDX_DEC;
            state_d = S_INS_RD;
          end
        end else begin
          cmd_o.wr_new = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.res_valid = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_INS_HEAD: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wr_new = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.res_valid = 1'b1;
        state_d = S_IDLE;
      end
      S_SRCH_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (sts_i.key_eq) begin
          cmd_o.save_hit = 1'b1;
          if (sts_i.is_find) begin
            cmd_o.res_valid = 1'b1;
            cmd_o.res_hit = 1'b1;
            cmd_o.res_addr = 1'b1;
            cmd_o.res_size_ram = 1'b1;
            state_d = S_IDLE;
          end else if (sts_i.idx_last) begin
            cmd_o.cnt_dec = 1'b1;
            cmd_o.res_valid = 1'b1;
            cmd_o.res_hit = 1'b1;
            cmd_o.res_size_ram = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_SHF_RD;
          end
        end else if (sts_i.idx_last) begin
          cmd_o.res_valid = 1'b1;
          cmd_o.res_status = ST_NOMATCH;
          state_d = S_IDLE;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d = S_SRCH_RD;
        end
      end
      S_SHF_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d = S_SHF_WR;
      end
      S_SHF_WR: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.shf_last) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.res_valid = 1'b1;
          cmd_o.res_hit = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d = S_SHF_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/sat_dp.sv @@
// record store, slot index, record count and result register
module sat_dp
  import sat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  req_t              req_q;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SIZE_W-1:0] hsize_q;
  logic              res_valid_q;
  res_t              res_q, res_d;
  rec_t              rd_data, wr_data;
  logic [IDX_W-1:0]  idx_up, rd_addr, wr_addr;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;

  assign idx_up  = idx_q + 1'b1;
  assign rd_addr = cmd_i.rd_next ? idx_up : idx_q;
  assign wr_addr = cmd_i.wr_up ? idx_up : idx_q;
  assign wr_data = cmd_i.wr_new ? rec_t'{key: req_q.address, size: req_q.alloc_size}
                                : rd_data;

  sat_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (cmd_i.rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    sts_o.cnt_zero = (cnt_q == '0);
    sts_o.cnt_full = (cnt_q == CNT_W'(TABLE_DEPTH));
    sts_o.key_ge   = (rd_data.key >= req_q.address);
    sts_o.key_eq   = (rd_data.key == req_q.address);
    sts_o.idx_zero = (idx_q == '0);
    sts_o.idx_last = (CNT_W'(idx_q) + 1'b1 == cnt_q);
    sts_o.shf_last = (CNT_W'(idx_q) + CNT_W'(2) == cnt_q);
    sts_o.is_find  = (req_q.opcode == OP_FIND);
  end

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_TOP:  idx_d = IDX_W'(cnt_q - 1'b1);
      IDX_ZERO: idx_d = '0;
      IDX_INC:  idx_d = idx_up;
      IDX_DEC:  idx_d = idx_q - 1'b1;
      default:  idx_d = idx_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  assign cnt_ext = {{OUT_CNT_W{1'b0}}, cnt_d};

  always_comb begin
    res_d.status      = cmd_i.res_status;
    res_d.hit         = cmd_i.res_hit;
    res_d.hit_address = cmd_i.res_addr ? rd_data.key : '0;
    res_d.hit_size    = !cmd_i.res_hit ? '0 : (cmd_i.res_size_ram ? rd_data.size : hsize_q);
    res_d.entry_count = cnt_ext[OUT_CNT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.save_hit) begin
      hsize_q <= rd_data.size;
    end
    idx_q <= idx_d;
    if (cmd_i.res_valid) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      res_valid_q <= cmd_i.res_valid;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ sv/sat_checker.sv @@
// port level checks of the sorted address table and their binding
module sat_checker
  import sat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic res_valid_o,
  input res_t res_o
);

  // an accepted word either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || res_valid_o)
    else $error("accepted word neither busy nor answered");

  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.hit |-> res_o.status == ST_OK)
    else $error("hit with error status");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == ST_FULL |-> res_o.entry_count == OUT_CNT_W'(TABLE_DEPTH))
    else $error("full status with table not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == ST_EMPTY |-> res_o.entry_count == '0)
    else $error("empty status with records held");

endmodule

bind sorted_address_table_top sat_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_sat_checker (.*);

@@ tb/tb_sorted_address_table_top.sv @@
// testbench of the sorted address table: directed rows, then random traffic against a predictor
module tb_sorted_address_table_top;
  import sat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned N_RAND   = 1800;
  localparam int unsigned NDIR_MAX = 25;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [KEY_W-1:0]  KEY_MAX  = '1;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  sorted_address_table_top #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the table
  logic [KEY_W-1:0]  tbl_key [DEPTH];
  logic [SIZE_W-1:0] tbl_size[DEPTH];
  int unsigned       tbl_count = 0;

  res_t pending_words[$];

  req_t        dir_req  [NDIR_MAX];
  bit          dir_typed[NDIR_MAX];
  res_t        dir_res  [NDIR_MAX];
  int unsigned n_dir = 0;

  int unsigned n_sent = 0;
  int unsigned n_fail = 0;
  int unsigned n_hits = 0, n_full = 0, n_empty = 0, n_nomatch = 0;
  int unsigned stall_cnt = 0;

  function automatic res_t mk_res(status_e st, logic h, logic [KEY_W-1:0] a,
                                  logic [SIZE_W-1:0] s, int unsigned c);
    res_t r;
    r.status = st;
    r.hit = h;
    r.hit_address = a;
    r.hit_size = s;
    r.entry_count = c[OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic req_t mk_req(opcode_e op, logic [KEY_W-1:0] a, logic [SIZE_W-1:0] s);
    req_t q;
    q.opcode = op;
    q.address = a;
    q.alloc_size = s;
    return q;
  endfunction

  task automatic add_row(req_t q, bit typed, res_t r);
    dir_req[n_dir] = q;
    dir_typed[n_dir] = typed;
    dir_res[n_dir] = r;
    n_dir++;
  endtask

  // applies one request to the shadow table and returns the word it should give
  function automatic res_t table_update(req_t q);
    res_t r;
    int unsigned pos;
    r = '0;
    r.status = ST_OK;
    case (opcode_e'(q.opcode))
      OP_INSERT: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_key[pos] < q.address) pos++;
          for (int j = tbl_count; j > pos; j--) begin
            tbl_key[j] = tbl_key[j-1];
            tbl_size[j] = tbl_size[j-1];
          end
          tbl_key[pos] = q.address;
          tbl_size[pos] = q.alloc_size;
          tbl_count++;
        end
      end
      OP_REMOVE, OP_FIND: begin
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_key[pos] != q.address) pos++;
          if (pos >= tbl_count) begin
            r.status = ST_NOMATCH;
          end else begin
            r.hit = 1'b1;
            r.hit_size = tbl_size[pos];
            if (q.opcode == OP_FIND) begin
              r.hit_address = tbl_key[pos];
            end else begin
              for (int j = pos; j + 1 < tbl_count; j++) begin
                tbl_key[j] = tbl_key[j+1];
                tbl_size[j] = tbl_size[j+1];
              end
              tbl_count--;
            end
          end
        end
      end
      default: ;
    endcase
    r.entry_count = tbl_count[OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_address();
    int unsigned m;
    logic [KEY_W-1:0] a;
    m = $urandom_range(0, 9);
    if (tbl_count > 0 && m <= 4) return tbl_key[$urandom_range(0, tbl_count - 1)];
    if (tbl_count > 0 && m == 9) begin
      a = tbl_key[$urandom_range(0, tbl_count - 1)];
      return $urandom_range(0, 1) ? a + KEY_W'(1) : a - KEY_W'(1);
    end
    if (m == 8) return $urandom_range(0, 1) ? KEY_MAX : '0;
    if (m == 7) return KEY_W'({$urandom, $urandom});
    return KEY_W'($urandom_range(0, 31));
  endfunction

  // phases alternate between filling, draining and mixed traffic
  function automatic req_t random_req(int unsigned k);
    int unsigned ins_pct, r;
    logic [SIZE_W-1:0] s;
    opcode_e op;
    case ((k / 150) % 3)
      0: ins_pct = 70;
      1: ins_pct = 30;
      default: ins_pct = 50;
    endcase
    r = $urandom_range(0, 99);
    if (r < 2) op = OP_NONE;
    else if (r < 2 + ins_pct) op = OP_INSERT;
    else if ($urandom_range(0, 1)) op = OP_REMOVE;
    else op = OP_FIND;
    case ($urandom_range(0, 7))
      0: s = '0;
      1: s = SIZE_MAX;
      default: s = $urandom;
    endcase
    return mk_req(op, pick_address(), s);
  endfunction

  function automatic req_t item_at(int unsigned k);
    if (k < n_dir) return dir_req[k];
    return random_req(k - n_dir);
  endfunction

  task automatic check_word(res_t exp_w, res_t got);
    if (got.status !== exp_w.status) begin
      $error("status: expected %0d, got %0d", exp_w.status, got.status);
      n_fail++;
    end
    if (got.hit !== exp_w.hit) begin
      $error("hit: expected %0d, got %0d", exp_w.hit, got.hit);
      n_fail++;
    end
    if (got.hit_address !== exp_w.hit_address) begin
      $error("hit_address: expected %h, got %h", exp_w.hit_address, got.hit_address);
      n_fail++;
    end
    if (got.hit_size !== exp_w.hit_size) begin
      $error("hit_size: expected %h, got %h", exp_w.hit_size, got.hit_size);
      n_fail++;
    end
    if (got.entry_count !== exp_w.entry_count) begin
      $error("entry_count: expected %0d, got %0d", exp_w.entry_count, got.entry_count);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    bit   accepted;
    bit   idle;
    res_t exp_w;
    if (rst_ni) begin
      accepted = start_i && !busy_o;
      if (res_valid_o) begin
        if (pending_words.size() == 0) begin
          $error("result word with nothing expected");
          n_fail++;
        end else begin
          check_word(pending_words.pop_front(), res_o);
        end
      end
      if (accepted) begin
        exp_w = table_update(req_i);
        if (n_sent < n_dir && dir_typed[n_sent]) exp_w = dir_res[n_sent];
        if (exp_w.hit) n_hits++;
        case (status_e'(exp_w.status))
          ST_FULL: n_full++;
          ST_EMPTY: n_empty++;
          ST_NOMATCH: n_nomatch++;
          default: ;
        endcase
        pending_words.push_back(exp_w);
        n_sent++;
      end
      stall_cnt <= (accepted || res_valid_o) ? 0 : stall_cnt + 1;
      if (accepted || !start_i) begin
        // a stretch with no idle cycles in the middle of the random part
        idle = !(n_sent >= n_dir + 600 && n_sent < n_dir + 900) &&
               ($urandom_range(0, 99) < 18);
        if (n_sent >= n_dir + N_RAND || idle) begin
          start_i <= 1'b0;
        end else begin
          start_i <= 1'b1;
          req_i <= item_at(n_sent);
        end
      end
    end
  end

  initial begin
    add_row(mk_req(OP_FIND,   48'd5, 32'd0), 1, mk_res(ST_EMPTY, 0, '0, '0, 0));
    add_row(mk_req(OP_REMOVE, 48'd5, 32'd9), 1, mk_res(ST_EMPTY, 0, '0, '0, 0));
    add_row(mk_req(OP_NONE, KEY_MAX, SIZE_MAX), 1, mk_res(ST_OK, 0, '0, '0, 0));
    add_row(mk_req(OP_INSERT, '0, '0), 1, mk_res(ST_OK, 0, '0, '0, 1));
    add_row(mk_req(OP_INSERT, KEY_MAX, SIZE_MAX), 1, mk_res(ST_OK, 0, '0, '0, 2));
    add_row(mk_req(OP_FIND, KEY_MAX, '0), 1, mk_res(ST_OK, 1, KEY_MAX, SIZE_MAX, 2));
    add_row(mk_req(OP_FIND, 48'd5, '0), 1, mk_res(ST_NOMATCH, 0, '0, '0, 2));
    add_row(mk_req(OP_NONE, 48'd0, 32'd7), 1, mk_res(ST_OK, 0, '0, '0, 2));
    // duplicate key goes in front of its equal
    add_row(mk_req(OP_INSERT, '0, 32'd1), 0, '0);
    add_row(mk_req(OP_FIND, '0, '0), 0, '0);
    add_row(mk_req(OP_REMOVE, '0, '0), 0, '0);
    add_row(mk_req(OP_REMOVE, '0, '0), 0, '0);
    add_row(mk_req(OP_REMOVE, KEY_MAX, '0), 1, mk_res(ST_OK, 1, '0, SIZE_MAX, 0));
    // single entry remove must still compare the address
    add_row(mk_req(OP_INSERT, 48'h9, 32'h5), 0, '0);
    add_row(mk_req(OP_REMOVE, 48'h8, '0), 1, mk_res(ST_NOMATCH, 0, '0, '0, 1));
    add_row(mk_req(OP_REMOVE, 48'h9, '0), 0, '0);
    add_row(mk_req(OP_INSERT, 48'h123456789abc, 32'hdeadbeef), 0, '0);
    add_row(mk_req(OP_INSERT, 48'h000000000010, 32'h1), 0, '0);
    add_row(mk_req(OP_INSERT, 48'h800000000000, 32'h2), 0, '0);
    add_row(mk_req(OP_FIND, 48'h123456789abc, '0), 0, '0);
    add_row(mk_req(OP_REMOVE, 48'h000000000010, '0), 0, '0);
    add_row(mk_req(OP_FIND, 48'h800000000000, '0), 0, '0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (n_sent >= n_dir + N_RAND && pending_words.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("run covered %0d requests: %0d hits, %0d no-match, %0d empty, %0d full",
             n_sent, n_hits, n_nomatch, n_empty, n_full);
    if (n_fail == 0 && pending_words.size() == 0) begin
      $display("** sorted_address_table_top: PASSED **");
    end else begin
      $display("** sorted_address_table_top: FAILED **");
    end
    $finish;
  end

  initial begin
    wait (stall_cnt >= STALL_LIMIT);
    $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
    $display("** sorted_address_table_top: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
sv/sat_pkg.sv
sv/sat_ram.sv
sv/sat_ctrl.sv
sv/sat_dp.sv
sv/sorted_address_table_top.sv
sv/sat_checker.sv
tb/tb_sorted_address_table_top.sv
